### hdl/lcpn_pkg.sv
// LCP option negotiator: shared types, protocol codes and the start request table.
// No dependencies; imported by every module of the block.
package lcpn_pkg;

  // option length field: covers the largest option store of the design range
  localparam int LEN_W = 6;
  localparam logic [5:0] COUNT_MAX = 6'd63;

  localparam logic [7:0] CODE_REQ = 8'd1;
  localparam logic [7:0] CODE_ACK = 8'd2;
  localparam logic [7:0] CODE_NAK = 8'd3;
  localparam logic [7:0] CODE_REJ = 8'd4;

  localparam logic [7:0] OPT_MRU   = 8'd1;
  localparam logic [7:0] OPT_ACCM  = 8'd2;
  localparam logic [7:0] OPT_AUTH  = 8'd3;
  localparam logic [7:0] OPT_MAGIC = 8'd5;

  localparam logic [31:0] MAGIC_RESET = 32'hCAFEBABE;
  localparam logic [15:0] MRU_RESET   = 16'd1500;
  localparam logic [6:0]  START_BYTES = 7'd20;

  typedef enum logic [1:0] {
    MODE_REJ = 2'd0,
    MODE_NAK = 2'd1,
    MODE_ACK = 2'd2
  } scan_mode_t;

  typedef struct packed {
    logic             is_start;
    logic [7:0]       ident;
    logic [LEN_W-1:0] len;
  } job_t;

  typedef struct packed {
    logic             we;
    logic [LEN_W-1:0] addr;
    logic [7:0]       data;
  } store_wr_t;

  // our own Configure-Request, byte by byte
  function automatic logic [7:0] start_byte(input logic [4:0] idx, input logic [31:0] m,
                                            input logic [15:0] mx);
    logic [7:0] b;
    b = 8'd0;
    unique case (idx)
      5'd0:    b = CODE_REQ;
      5'd3:    b = 8'(START_BYTES);
      5'd4:    b = OPT_MAGIC;
      5'd5:    b = 8'd6;
      5'd6:    b = m[31:24];
      5'd7:    b = m[23:16];
      5'd8:    b = m[15:8];
      5'd9:    b = m[7:0];
      5'd10:   b = OPT_ACCM;
      5'd11:   b = 8'd6;
      5'd16:   b = OPT_MRU;
      5'd17:   b = 8'd4;
      5'd18:   b = mx[15:8];
      5'd19:   b = mx[7:0];
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

### hdl/lcpn_front.sv
// LCP negotiator front end: parses received packet bytes, fills the option store,
// raises jobs for the back end. Depends on lcpn_pkg.
module lcpn_front #(
  parameter int OPTION_BYTES = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_start,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic              job_full,
  input  logic              job_empty,
  input  logic              back_idle,
  output logic              job_push,
  output lcpn_pkg::job_t    job,
  output lcpn_pkg::store_wr_t wr,
  output logic              host_done
);
  import lcpn_pkg::*;

  logic [5:0]       count_r, count_nxt, c_new, olen;
  logic [7:0]       code_r, code_nxt, ident_r, ident_nxt;
  logic [15:0]      rxlen_r, rxlen_nxt, rxlen_m4;
  logic             host_done_r, host_done_nxt;
  logic             accept, pkt, pkt_end, store_ok;
  logic [LEN_W-1:0] len_c;

  assign in_ready = in_start ? !job_full : (job_empty && back_idle);
  assign accept   = in_valid && in_ready;
  assign pkt      = accept && !in_start;
  assign c_new    = (count_r < COUNT_MAX) ? count_r + 6'd1 : count_r;
  assign pkt_end  = pkt && in_last && (c_new >= 6'd4);
  assign store_ok = (count_r >= 6'd4) && (7'(count_r - 6'd4) < 7'(OPTION_BYTES));

  always_comb begin
    code_nxt  = code_r;
    ident_nxt = ident_r;
    rxlen_nxt = rxlen_r;
    if (pkt && count_r < COUNT_MAX) begin
      priority if (count_r == 6'd0) code_nxt = in_byte;
      else if (count_r == 6'd1) ident_nxt = in_byte;
      else if (count_r == 6'd2) rxlen_nxt = {in_byte, rxlen_r[7:0]};
      else if (count_r == 6'd3) rxlen_nxt = {rxlen_r[15:8], in_byte};
    end
  end

  assign count_nxt = pkt ? (in_last ? 6'd0 : c_new) : count_r;

  // usable option length: stored bytes, clipped to the header length
  assign rxlen_m4 = rxlen_nxt - 16'd4;
  always_comb begin
    olen = c_new - 6'd4;
    if (7'(olen) > 7'(OPTION_BYTES)) olen = 6'(OPTION_BYTES);
    len_c = olen;
    if (rxlen_nxt < 16'd4) len_c = '0;
    else if (rxlen_m4 < 16'(olen)) len_c = rxlen_m4[LEN_W-1:0];
  end

  assign wr.we   = pkt && (count_r < COUNT_MAX) && store_ok;
  assign wr.addr = count_r - 6'd4;
  assign wr.data = in_byte;

  assign job_push     = accept && (in_start || (pkt_end && code_nxt == CODE_REQ));
  assign job.is_start = in_start;
  assign job.ident    = ident_nxt;
  assign job.len      = len_c;

  assign host_done_nxt = host_done_r | (pkt_end && code_nxt == CODE_ACK);
  assign host_done     = host_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      code_r      <= '0;
      ident_r     <= '0;
      rxlen_r     <= '0;
      host_done_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      code_r      <= code_nxt;
      ident_r     <= ident_nxt;
      rxlen_r     <= rxlen_nxt;
      host_done_r <= host_done_nxt;
    end
  end

`ifndef SYNTH
  a_store_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    wr.we |-> (back_idle && job_empty))
    else $error("option store written while a reply is pending");
`endif

endmodule

### hdl/lcpn_queue.sv
// Two-entry job queue between the LCP front end and back end.
// Depends on lcpn_pkg for the job type.
module lcpn_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lcpn_pkg::job_t push_job,
  input  logic           pop,
  output lcpn_pkg::job_t head,
  output logic           full,
  output logic           empty
);
  import lcpn_pkg::*;

  job_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

### hdl/lcpn_back.sv
// LCP negotiator back end: option store, reject/nak/ack scan sequencer and reply
// output register. Depends on lcpn_pkg.
module lcpn_back #(
  parameter int OPTION_BYTES = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lcpn_pkg::store_wr_t wr,
  input  logic                job_empty,
  input  lcpn_pkg::job_t      job,
  output logic                job_pop,
  output logic                idle,
  input  logic [15:0]         max_mru,
  input  logic                host_done,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [63:0]         out_tdata,
  output logic                out_tlast
);
  import lcpn_pkg::*;

  localparam int AW = $clog2(OPTION_BYTES);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_START = 11'b00000000010,
    S_OPT   = 11'b00000000100,
    S_TYP   = 11'b00000001000,
    S_LEN   = 11'b00000010000,
    S_VAL   = 11'b00000100000,
    S_ACT   = 11'b00001000000,
    S_EMIT  = 11'b00010000000,
    S_PEND  = 11'b00100000000,
    S_HDR   = 11'b01000000000,
    S_ACKEM = 11'b10000000000
  } state_t;

  logic [7:0] mem [OPTION_BYTES];

  state_t           state_r, state_nxt;
  scan_mode_t       mode_r, mode_nxt;
  logic             emit_r, emit_nxt;
  logic [LEN_W-1:0] pos_r, pos_nxt, len_r, len_nxt, plen_r, plen_nxt;
  logic [7:0]       k_r, k_nxt, t_r, t_nxt, ol_r, ol_nxt, ident_r, ident_nxt;
  logic [7:0]       code_r, code_nxt, rdata_r;
  logic [31:0]      val_r, val_nxt, magic_r, magic_nxt;
  logic [15:0]      mru_r, mru_nxt;
  logic [6:0]       rem_r, rem_nxt;
  logic             rv_r, cdone_r, cdone_nxt;
  logic             out_valid_r;
  logic [63:0]      out_data_r;
  logic             out_last_r;

  logic             out_free, out_load, sel;
  logic [7:0]       out_byte, vbyte;
  logic [8:0]       pos9, len9, ol9, k9, rd_sum;
  logic [AW-1:0]    rd_addr;

  assign pos9     = 9'(pos_r);
  assign len9     = 9'(len_r);
  assign ol9      = 9'(ol_r);
  assign k9       = 9'(k_r);
  assign rd_sum   = pos9 + k9;
  assign rd_addr  = rd_sum[AW-1:0];
  assign out_free = !out_valid_r || out_tready;
  assign idle     = (state_r == S_IDLE);
  assign vbyte    = (rd_sum < len9) ? rdata_r : 8'd0;

  always_comb begin
    priority if (mode_r == MODE_NAK && t_r == OPT_MRU) sel = (val_r[31:16] > max_mru);
    else if (mode_r == MODE_REJ)
      sel = (t_r != OPT_MRU) && (t_r != OPT_ACCM) && (t_r != OPT_AUTH) && (t_r != OPT_MAGIC);
    else sel = 1'b0;
  end

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    emit_nxt  = emit_r;
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    plen_nxt  = plen_r;
    k_nxt     = k_r;
    t_nxt     = t_r;
    ol_nxt    = ol_r;
    ident_nxt = ident_r;
    code_nxt  = code_r;
    val_nxt   = val_r;
    magic_nxt = magic_r;
    mru_nxt   = mru_r;
    rem_nxt   = rem_r;
    cdone_nxt = cdone_r;
    job_pop   = 1'b0;
    out_load  = 1'b0;
    out_byte  = rdata_r;
    unique case (state_r)
      S_IDLE: begin
        if (!job_empty) begin
          job_pop = 1'b1;
          if (job.is_start) begin
            state_nxt = S_START;
            k_nxt     = '0;
            rem_nxt   = START_BYTES;
          end else begin
            ident_nxt = job.ident;
            len_nxt   = job.len;
            mode_nxt  = MODE_REJ;
            emit_nxt  = 1'b0;
            pos_nxt   = '0;
            plen_nxt  = '0;
            state_nxt = S_OPT;
          end
        end
      end
      S_START: begin
        if (out_free) begin
          out_load = 1'b1;
          out_byte = start_byte(k_r[4:0], ~magic_r, max_mru);
          k_nxt    = k_r + 8'd1;
          rem_nxt  = rem_r - 7'd1;
          if (rem_r == 7'd1) state_nxt = S_IDLE;
        end
      end
      S_OPT: begin
        if (pos9 + 9'd2 <= len9) begin
          k_nxt     = 8'd0;
          state_nxt = S_TYP;
        end else begin
          state_nxt = S_PEND;
        end
      end
      S_TYP: begin
        if (rv_r) begin
          t_nxt     = rdata_r;
          k_nxt     = 8'd1;
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        if (rv_r) begin
          ol_nxt = rdata_r;
          // malformed option ends the scan
          if (rdata_r < 8'd2 || pos9 + 9'(rdata_r) > len9) begin
            state_nxt = S_PEND;
          end else begin
            val_nxt   = '0;
            k_nxt     = 8'd2;
            state_nxt = S_VAL;
          end
        end
      end
      S_VAL: begin
        if (rv_r) begin
          val_nxt = {val_r[23:0], vbyte};
          if (k_r == 8'd5) state_nxt = S_ACT;
          else k_nxt = k_r + 8'd1;
        end
      end
      S_ACT: begin
        if (mode_r == MODE_ACK) begin
          if (t_r == OPT_MRU) mru_nxt = val_r[31:16];
          if (t_r == OPT_MAGIC) magic_nxt = val_r;
        end
        if (sel && emit_r) begin
          k_nxt     = 8'd0;
          state_nxt = S_EMIT;
        end else begin
          if (sel) plen_nxt = plen_r + ol_r[LEN_W-1:0];
          pos_nxt   = LEN_W'(pos9 + ol9);
          state_nxt = S_OPT;
        end
      end
      S_EMIT: begin
        if (rv_r && out_free) begin
          out_load = 1'b1;
          if (mode_r == MODE_NAK && k_r == 8'd2) out_byte = max_mru[15:8];
          else if (mode_r == MODE_NAK && k_r == 8'd3) out_byte = max_mru[7:0];
          rem_nxt = rem_r - 7'd1;
          if (k9 + 9'd1 == ol9) begin
            pos_nxt   = LEN_W'(pos9 + ol9);
            state_nxt = S_OPT;
          end else begin
            k_nxt = k_r + 8'd1;
          end
        end
      end
      S_PEND: begin
        if (emit_r) begin
          state_nxt = S_IDLE;
        end else begin
          unique case (mode_r)
            MODE_REJ: begin
              if (plen_r != '0) begin
                code_nxt  = CODE_REJ;
                state_nxt = S_HDR;
              end else begin
                mode_nxt  = MODE_NAK;
                state_nxt = S_OPT;
              end
            end
            MODE_NAK: begin
              if (plen_r != '0) begin
                code_nxt  = CODE_NAK;
                state_nxt = S_HDR;
              end else begin
                mode_nxt  = MODE_ACK;
                state_nxt = S_OPT;
              end
            end
            default: begin
              cdone_nxt = 1'b1;
              code_nxt  = CODE_ACK;
              plen_nxt  = len_r;
              state_nxt = S_HDR;
            end
          endcase
          pos_nxt = '0;
          k_nxt   = 8'd0;
          if (state_nxt == S_HDR) begin
            emit_nxt = 1'b1;
            rem_nxt  = 7'(mode_r == MODE_ACK ? len_r : plen_r) + 7'd4;
          end
        end
      end
      S_HDR: begin
        if (out_free) begin
          out_load = 1'b1;
          unique case (k_r[1:0])
            2'd0:    out_byte = code_r;
            2'd1:    out_byte = ident_r;
            2'd2:    out_byte = 8'd0;
            default: out_byte = 8'(plen_r) + 8'd4;
          endcase
          rem_nxt = rem_r - 7'd1;
          if (k_r == 8'd3) begin
            k_nxt     = 8'd0;
            pos_nxt   = '0;
            state_nxt = (code_r == CODE_ACK) ? S_ACKEM : S_OPT;
          end else begin
            k_nxt = k_r + 8'd1;
          end
        end
      end
      S_ACKEM: begin
        if (pos_r == len_r) begin
          state_nxt = S_IDLE;
        end else if (rv_r && out_free) begin
          out_load = 1'b1;
          rem_nxt  = rem_r - 7'd1;
          pos_nxt  = pos_r + LEN_W'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr.we) mem[wr.addr[AW-1:0]] <= wr.data;
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {6'd0, magic_r, mru_r, host_done, cdone_r, out_byte};
      out_last_r <= (rem_r == 7'd1);
    end
    mode_r  <= mode_nxt;
    pos_r   <= pos_nxt;
    len_r   <= len_nxt;
    plen_r  <= plen_nxt;
    k_r     <= k_nxt;
    t_r     <= t_nxt;
    ol_r    <= ol_nxt;
    ident_r <= ident_nxt;
    code_r  <= code_nxt;
    val_r   <= val_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      emit_r      <= 1'b0;
      rem_r       <= '0;
      rv_r        <= 1'b0;
      cdone_r     <= 1'b0;
      magic_r     <= MAGIC_RESET;
      mru_r       <= MRU_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      emit_r  <= emit_nxt;
      rem_r   <= rem_nxt;
      // read data is good once the address has held still and no store write came between
      rv_r    <= (k_nxt == k_r) && (pos_nxt == pos_r) && !wr.we;
      cdone_r <= cdone_nxt;
      magic_r <= magic_nxt;
      mru_r   <= mru_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  a_cdone_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    cdone_r |=> cdone_r)
    else $error("client_done cleared outside reset");
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (rem_r == 7'd0))
    else $error("reply finished with beats outstanding");
  a_load_states: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (state_r == S_START || state_r == S_HDR || state_r == S_EMIT ||
                  state_r == S_ACKEM))
    else $error("reply beat loaded outside an emitting state");
`endif

endmodule

### hdl/ppp_lcp_option_negotiator_core.sv
// PPP LCP option negotiator top level: front end, job queue, back end, max_mru register.
// Depends on lcpn_pkg, lcpn_front, lcpn_queue, lcpn_back.
//
// Received LCP bytes (in_tuser low) are taken one per cycle and their options kept in a
// store of OPTION_BYTES bytes; a start beat (in_tuser high) queues our own 20-byte
// Configure-Request. At the end of a Configure-Request the back end scans the options
// for rejects, then for MRU naks, then takes over MRU and magic number, and replies with
// the same identifier. Each scan pass reads six bytes of every option through one store
// read port with a registered read; while a reply is pending, packet beats are held off
// and start beats queue up to two deep. Reply beats wait in an output register while
// the back end goes on.
module ppp_lcp_option_negotiator_core #(
  parameter int OPTION_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] opcode
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [7:0] reply_byte, [8] client_done, [9] host_done,
                                  // [25:10] link_mru, [57:26] peer_magic
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import lcpn_pkg::*;

  logic [15:0] max_mru_r;
  logic        job_push, job_pop, job_full, job_empty, back_idle, host_done;
  job_t        push_job, head_job;
  store_wr_t   wr;

  always_ff @(posedge clk) begin
    if (!rst_n) max_mru_r <= MRU_RESET;
    else if (cfg_we) max_mru_r <= cfg_wdata;
  end

  lcpn_front #(.OPTION_BYTES(OPTION_BYTES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_start  (in_tuser),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .job_full  (job_full),
    .job_empty (job_empty),
    .back_idle (back_idle),
    .job_push  (job_push),
    .job       (push_job),
    .wr        (wr),
    .host_done (host_done)
  );

  lcpn_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (push_job),
    .pop      (job_pop),
    .head     (head_job),
    .full     (job_full),
    .empty    (job_empty)
  );

  lcpn_back #(.OPTION_BYTES(OPTION_BYTES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (wr),
    .job_empty  (job_empty),
    .job        (head_job),
    .job_pop    (job_pop),
    .idle       (back_idle),
    .max_mru    (max_mru_r),
    .host_done  (host_done),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

### test/lcpn_checker.sv
// Checker for the LCP option negotiator: watches input and reply channels, predicts the
// reply bytes and status fields, and compares every reply beat. Depends on lcpn_pkg.
`timescale 1ns / 1ps
module lcpn_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output int          errors,
  output int          pending
);
  import lcpn_pkg::*;

  typedef struct packed {
    logic [7:0]  rbyte;
    logic        rlast;
    logic        cdone;
    logic        hdone;
    logic [15:0] mru;
    logic [31:0] magic;
  } reply_t;

  reply_t      reply_q[$];
  logic [7:0]  opts[32];
  logic [5:0]  nbytes;
  logic [7:0]  code_r, ident_r;
  logic [15:0] hlen_r, mru_r, limit_r;
  logic [31:0] magic_r;
  logic [1:0]  flags_r;
  logic [7:0]  pkt[36];

  assign pending = reply_q.size();

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [7:0] opt_at(input int i, input int n);
    return (i < n && i < 32) ? opts[i] : 8'd0;
  endfunction

  // one pass over the options; returns payload length written into pkt[4..]
  function automatic int scan_opts(input scan_mode_t mode, input int n);
    int pos, w, ol, k;
    logic [7:0] t, b;
    logic [15:0] v;
    pos = 0; w = 0;
    while (pos + 2 <= n) begin
      t = opts[pos]; ol = opts[pos+1];
      if (ol < 2 || pos + ol > n) break;
      if (t == OPT_MRU) begin
        v = {opt_at(pos+2, n), opt_at(pos+3, n)};
        if (mode == MODE_ACK) mru_r = v;
        else if (mode == MODE_NAK && v > limit_r)
          for (k = 0; k < ol; k++) begin
            b = opts[pos+k];
            if (k == 2) b = limit_r[15:8];
            if (k == 3) b = limit_r[7:0];
            pkt[4+w] = b; w++;
          end
      end else if (t == OPT_MAGIC) begin
        if (mode == MODE_ACK)
          magic_r = {opt_at(pos+2, n), opt_at(pos+3, n), opt_at(pos+4, n), opt_at(pos+5, n)};
      end else if (t != OPT_ACCM && t != OPT_AUTH) begin
        if (mode == MODE_REJ)
          for (k = 0; k < ol; k++) begin
            pkt[4+w] = opts[pos+k]; w++;
          end
      end
      pos += ol;
    end
    if (mode == MODE_ACK) begin
      for (k = 0; k < n; k++) pkt[4+k] = opts[k];
      return n;
    end
    return w;
  endfunction

  task automatic queue_reply(input logic [7:0] code, input logic [7:0] ident, input int plen);
    reply_t r;
    logic [15:0] total;
    total = 16'(plen + 4);
    pkt[0] = code; pkt[1] = ident; pkt[2] = total[15:8]; pkt[3] = total[7:0];
    for (int k = 0; k < plen + 4; k++) begin
      r.rbyte = pkt[k];
      r.rlast = (k == plen + 3);
      r.cdone = flags_r[0];
      r.hdone = flags_r[1];
      r.mru = mru_r;
      r.magic = magic_r;
      reply_q.push_back(r);
    end
  endtask

  task automatic take_beat(input logic start, input logic [7:0] b, input logic eop);
    int c, n, plen;
    logic [31:0] m;
    if (start) begin
      m = ~magic_r;
      pkt[4] = OPT_MAGIC; pkt[5] = 8'd6;
      pkt[6] = m[31:24]; pkt[7] = m[23:16]; pkt[8] = m[15:8]; pkt[9] = m[7:0];
      pkt[10] = OPT_ACCM; pkt[11] = 8'd6;
      pkt[12] = 8'd0; pkt[13] = 8'd0; pkt[14] = 8'd0; pkt[15] = 8'd0;
      pkt[16] = OPT_MRU; pkt[17] = 8'd4; pkt[18] = limit_r[15:8]; pkt[19] = limit_r[7:0];
      queue_reply(CODE_REQ, 8'd0, 16);
      return;
    end
    c = nbytes;
    if (c < 63) begin
      if (c == 0) code_r = b;
      else if (c == 1) ident_r = b;
      else if (c == 2) hlen_r[15:8] = b;
      else if (c == 3) hlen_r[7:0] = b;
      else if (c - 4 < 32) opts[c-4] = b;
      c++;
    end
    nbytes = 6'(c);
    if (!eop) return;
    nbytes = 0;
    if (c < 4) return;
    n = c - 4;
    if (n > 32) n = 32;
    if (hlen_r < 4) n = 0;
    else if (hlen_r - 4 < n) n = hlen_r - 4;
    if (code_r == CODE_ACK) begin
      flags_r[1] = 1'b1;
      return;
    end
    if (code_r != CODE_REQ) return;
    plen = scan_opts(MODE_REJ, n);
    if (plen != 0) begin
      queue_reply(CODE_REJ, ident_r, plen);
      return;
    end
    plen = scan_opts(MODE_NAK, n);
    if (plen != 0) begin
      queue_reply(CODE_NAK, ident_r, plen);
      return;
    end
    plen = scan_opts(MODE_ACK, n);
    flags_r[0] = 1'b1;
    queue_reply(CODE_ACK, ident_r, plen);
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      reply_q.delete();
      nbytes = 0; code_r = 0; ident_r = 0; hlen_r = 0;
      magic_r = MAGIC_RESET; mru_r = MRU_RESET; limit_r = MRU_RESET; flags_r = 0;
      errors = 0;
    end else begin
      if (cfg_we) limit_r = cfg_wdata;
      if (out_tvalid && out_tready) begin
        if (reply_q.size() == 0) begin
          report("unexpected beat", out_tdata, 0);
        end else begin
          want = reply_q.pop_front();
          if (out_tdata[7:0] !== want.rbyte) report("reply_byte", out_tdata[7:0], want.rbyte);
          if (out_tlast !== want.rlast) report("reply_last", out_tlast, want.rlast);
          if (out_tdata[8] !== want.cdone) report("client_done", out_tdata[8], want.cdone);
          if (out_tdata[9] !== want.hdone) report("host_done", out_tdata[9], want.hdone);
          if (out_tdata[25:10] !== want.mru) report("link_mru", out_tdata[25:10], want.mru);
          if (out_tdata[57:26] !== want.magic)
            report("peer_magic", out_tdata[57:26], want.magic);
        end
      end
      if (in_tvalid && in_tready) take_beat(in_tuser, in_tdata, in_tlast);
    end
  end
endmodule

### test/testbench.sv
// Top of the LCP option negotiator testbench: clock, reset, stimulus and verdict.
// Depends on lcpn_pkg, lcpn_checker and ppp_lcp_option_negotiator_core.
`timescale 1ns / 1ps
module testbench;
  import lcpn_pkg::*;

  logic        clk, rst_n;
  logic        in_tvalid, in_tready, in_tuser, in_tlast;
  logic [7:0]  in_tdata;
  logic        out_tvalid, out_tready, out_tlast;
  logic [63:0] out_tdata;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  int          errors, pending;
  int          send_idle, recv_idle;
  int          hold_cycles;
  int          quiet;
  logic [7:0]  frame[$];

  ppp_lcp_option_negotiator_core dut (.*);
  lcpn_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // valid stays up after the beat; drain, or an idle gap in the next send, drops it
  task automatic send(input logic start, input logic [7:0] b, input logic eop);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= start;
    in_tdata <= b;
    in_tlast <= eop;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame.size(); i++) send(1'b0, frame[i], i == frame.size() - 1);
    frame.delete();
  endtask

  // header with the true length
  task automatic build_req(input logic [7:0] code, input logic [7:0] ident);
    int n;
    n = frame.size() + 4;
    frame.push_front(8'(n));
    frame.push_front(8'(n >> 8));
    frame.push_front(ident);
    frame.push_front(code);
  endtask

  task automatic add_opt(input logic [7:0] t, input int olen);
    frame.push_back(t);
    frame.push_back(8'(olen));
    for (int k = 2; k < olen; k++) frame.push_back(8'($urandom));
  endtask

  task automatic add_mru(input logic [15:0] v);
    frame.push_back(OPT_MRU); frame.push_back(8'd4);
    frame.push_back(v[15:8]); frame.push_back(v[7:0]);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    cfg_we <= 1'b1; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_packet();
    int r, nopt;
    logic [7:0] kinds[5] = '{OPT_MRU, OPT_ACCM, OPT_AUTH, OPT_MAGIC, 8'd0};
    r = $urandom_range(99);
    if (r < 8) begin
      send(1'b1, 8'($urandom), 1'($urandom));
      return;
    end
    nopt = $urandom_range(0, 2);
    for (int i = 0; i < nopt; i++) begin
      if ($urandom_range(3) == 0) add_mru(16'($urandom_range(1400, 1600)));
      else if ($urandom_range(9) == 0) add_opt(8'($urandom), $urandom_range(2, 6));
      else add_opt(kinds[$urandom_range(3)], $urandom_range(2, 6));
    end
    if (r < 75) build_req(CODE_REQ, 8'($urandom));
    else if (r < 85) build_req(CODE_ACK, 8'($urandom));
    else begin
      // noise: random header, maybe broken length or short frame
      frame.push_front(8'($urandom));
      frame.push_front(8'($urandom));
      frame.push_front(8'($urandom));
      frame.push_front(8'($urandom_range(0, 5)));
      if ($urandom_range(1)) frame = frame[0:$urandom_range(0, 3)];
    end
    send_frame();
  endtask

  initial begin
    rst_n = 0; in_tvalid = 0; in_tdata = 0; in_tuser = 0; in_tlast = 0;
    out_tready = 0; cfg_we = 0; cfg_wdata = 0; send_idle = 0; recv_idle = 0;
    hold_cycles = 0; quiet = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: start, plain ack, nak, reject, malformed, short, long, bad length, unknown code, peer ack
    send(1'b1, 8'hFF, 1'b1);
    add_opt(OPT_MAGIC, 6); add_opt(OPT_ACCM, 6); add_mru(16'd1000);
    build_req(CODE_REQ, 8'hFF); send_frame();
    add_mru(16'hFFFF); add_opt(OPT_MAGIC, 6); build_req(CODE_REQ, 8'h00); send_frame();
    add_opt(8'd7, 2); add_opt(8'hFF, 3); add_opt(OPT_MRU, 4); build_req(CODE_REQ, 8'h5A);
    send_frame();
    frame.push_back(OPT_ACCM); frame.push_back(8'd1); frame.push_back(8'd0);
    build_req(CODE_REQ, 8'h11); send_frame();
    frame.push_back(OPT_MRU); frame.push_back(8'd3); frame.push_back(8'hFF);
    build_req(CODE_REQ, 8'h12); send_frame();
    send(1'b0, CODE_REQ, 1'b0); send(1'b0, 8'h01, 1'b1);
    for (int i = 0; i < 66; i++) frame.push_back(i < 4 ? 8'd0 : 8'($urandom));
    frame[0] = CODE_REQ; frame[3] = 8'd40; send_frame();
    frame = '{CODE_REQ, 8'h22, 8'h00, 8'h02}; send_frame();
    build_req(8'h09, 8'h33); send_frame();
    build_req(CODE_ACK, 8'h44); send_frame();
    drain();

    write_limit(16'd0);
    add_mru(16'd1); build_req(CODE_REQ, 8'h01); send_frame();
    send(1'b1, 8'h00, 1'b0);
    drain();
    write_limit(16'hFFFF);
    add_mru(16'hFFFF); build_req(CODE_REQ, 8'h02); send_frame();
    send(1'b1, 8'hAA, 1'b0);
    drain();
    write_limit(16'd1500);

    for (int phase = 0; phase < 4; phase++) begin
      send_idle = (phase == 1 || phase == 3) ? (phase == 1 ? 55 : 26) : 0;
      recv_idle = (phase == 2 || phase == 3) ? (phase == 2 ? 55 : 26) : 0;
      random_packet();
      if (phase == 1) begin
        // long receiver hold-off while starts keep arriving
        hold_cycles <= 600;
        for (int i = 0; i < 4; i++) send(1'b1, 8'($urandom), 1'b0);
      end
      drain();
      write_limit(16'($urandom_range(1400, 1600)));
    end
    send_idle = 0; recv_idle = 0;

    while (pending != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

### files.f
hdl/lcpn_pkg.sv
hdl/lcpn_front.sv
hdl/lcpn_queue.sv
hdl/lcpn_back.sv
hdl/ppp_lcp_option_negotiator_core.sv
test/lcpn_checker.sv
test/testbench.sv
